// ===== sv/tws_pkg.sv =====
package tws_pkg;

  localparam int WORD_W = 16;
  localparam int POS_W  = 8;
  localparam int STEP_W = 8;
  localparam int ACC_W  = 16;

  // position + step + accumulator fits in this many bits
  localparam int DIV_BITS = ACC_W + 1;
  localparam int CNT_W    = $clog2(DIV_BITS);

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STEP   = 2'd1;
  localparam logic [1:0] ACT_REWIND = 2'd2;

  localparam logic [1:0] CFG_ONE_SHOT      = 2'd0;
  localparam logic [1:0] CFG_TABLE_SIZE    = 2'd1;
  localparam logic [1:0] CFG_FINISHED_HOLD = 2'd2;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_last;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

endpackage

// ===== sv/table_waveform_stepper_top.sv =====
// Channel  Handshake            Payload
// in       in_valid/in_ready    action, entry_index, entry_voltage, entry_hold,
//                               step_size, paused
// out      out_valid/out_ready  voltage, hold_time, position
// cfg      cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// Load, rewind, unused action codes, paused steps and clamped one-shot steps
// pass from acceptance through the read and wait states to the output register;
// an applied step first runs the bit-serial remainder unit that reduces position
// + step + pause sum modulo the table size, one dividend bit per cycle.
// One transaction is in flight at a time; the output register lets the next
// transaction enter while a result still waits on out_ready.
// rst is synchronous and active high; table contents are not cleared.
module table_waveform_stepper_top #(
  parameter int TABLE_DEPTH  = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  entry_index,
  input  logic [15:0] entry_voltage,
  input  logic [15:0] entry_hold,
  input  logic [7:0]  step_size,
  input  logic        paused,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] voltage,
  output logic [15:0] hold_time,
  output logic [7:0]  position,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tws_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequence the transaction: accept, iterate the remainder, read, deliver
  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold the tables, position, pause sum, registers and output register
  tws_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .entry_index   (entry_index),
    .entry_voltage (entry_voltage),
    .entry_hold    (entry_hold),
    .step_size     (step_size),
    .paused        (paused),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .voltage       (voltage),
    .hold_time     (hold_time),
    .position      (position)
  );

endmodule

// ===== sv/tws_ram.sv =====
module tws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tws_ctrl.sv =====
module tws_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tws_pkg::stat_t stat,
  output tws_pkg::cmd_t  cmd
);
  import tws_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;
  logic             out_valid_next;
  logic             div_done;

  assign in_ready = (state == S_IDLE);
  assign div_done = (div_cnt == CNT_W'(DIV_BITS - 1));

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.accept   = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next   = stat.need_div ? S_DIV : S_READ;
          div_cnt_next = '0;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = div_done;
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/tws_datapath.sv =====
module tws_datapath #(
  parameter int TABLE_DEPTH  = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tws_pkg::cmd_t                cmd,
  output tws_pkg::stat_t               stat,
  input  logic [1:0]                   action,
  input  logic [tws_pkg::POS_W-1:0]    entry_index,
  input  logic [tws_pkg::WORD_W-1:0]   entry_voltage,
  input  logic [tws_pkg::WORD_W-1:0]   entry_hold,
  input  logic [tws_pkg::STEP_W-1:0]   step_size,
  input  logic                         paused,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [tws_pkg::WORD_W-1:0]   cfg_data,
  output logic [tws_pkg::WORD_W-1:0]   voltage,
  output logic [tws_pkg::WORD_W-1:0]   hold_time,
  output logic [tws_pkg::POS_W-1:0]    position
);
  import tws_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic                    play_once;
  logic [POS_W-1:0]        table_size;
  logic [WORD_W-1:0]       finished_hold;
  logic [POS_W-1:0]        cur_pos;
  logic [ACC_W-1:0]        acc;
  logic [DIV_BITS-1:0]     dividend;
  logic [POS_W-1:0]        rem;

  logic [POS_W:0]          n_used;
  logic [POS_W-1:0]        last_pos;
  logic [POS_W:0]          fwd;
  logic                    clamp;
  logic                    load_ok;
  logic                    load_we;
  logic [DIV_BITS-1:0]     sum;
  logic [POS_W:0]          trial;
  logic [POS_W-1:0]        rem_next;
  logic [SAMPLE_WIDTH-1:0] volt_rdata;
  logic [SAMPLE_WIDTH-1:0] hold_rdata;

  // entries in use: zero acts as one, limited to the table depth
  always_comb begin
    n_used = {1'b0, table_size};
    if (table_size == '0) begin
      n_used = (POS_W + 1)'(1);
    end
    if (n_used > (POS_W + 1)'(TABLE_DEPTH)) begin
      n_used = (POS_W + 1)'(TABLE_DEPTH);
    end
  end

  assign last_pos = POS_W'(n_used - (POS_W + 1)'(1));
  assign fwd      = {1'b0, cur_pos} + {1'b0, step_size};
  assign clamp    = play_once && (fwd >= {1'b0, last_pos});
  assign sum      = DIV_BITS'(fwd) + DIV_BITS'(acc);
  assign load_ok  = ({1'b0, entry_index} < (POS_W + 1)'(TABLE_DEPTH));
  assign load_we  = cmd.accept && (action == ACT_LOAD) && load_ok;

  assign stat.need_div = (action == ACT_STEP) && !paused && !clamp;

  // one restoring step of the remainder
  always_comb begin
    trial    = {rem, dividend[DIV_BITS-1]};
    rem_next = trial[POS_W-1:0];
    if (trial >= n_used) begin
      rem_next = POS_W'(trial - n_used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_once     <= 1'b0;
      table_size    <= POS_W'(1);
      finished_hold <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_SHOT:      play_once     <= cfg_data[0];
        CFG_TABLE_SIZE:    table_size    <= cfg_data[POS_W-1:0];
        CFG_FINISHED_HOLD: finished_hold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos <= '0;
      acc     <= '0;
    end else if (cmd.accept) begin
      if (action == ACT_STEP) begin
        if (paused) begin
          acc <= acc + ACC_W'(step_size);
        end else begin
          acc <= '0;
          if (clamp) begin
            cur_pos <= last_pos;
          end
        end
      end else if (action == ACT_REWIND) begin
        cur_pos <= '0;
      end
    end else if (cmd.div_last) begin
      cur_pos <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dividend <= sum;
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[DIV_BITS-2:0], 1'b0};
      rem      <= rem_next;
    end
  end

  tws_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(TABLE_DEPTH)) u_volt_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (entry_index[ADDR_W-1:0]),
    .wdata (SAMPLE_WIDTH'(entry_voltage)),
    .raddr (cur_pos[ADDR_W-1:0]),
    .rdata (volt_rdata)
  );

  tws_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(TABLE_DEPTH)) u_hold_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (entry_index[ADDR_W-1:0]),
    .wdata (SAMPLE_WIDTH'(entry_hold)),
    .raddr (cur_pos[ADDR_W-1:0]),
    .rdata (hold_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      voltage   <= WORD_W'(volt_rdata);
      hold_time <= (play_once && (cur_pos == last_pos)) ? finished_hold
                                                         : WORD_W'(hold_rdata);
      position  <= cur_pos;
    end
  end

endmodule

// ===== verif/tb_table_waveform_stepper_top.sv =====
`timescale 1ns / 100ps

module tb_table_waveform_stepper_top;
  import tws_pkg::*;

  // Action and register codes that the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Applied steps are the slowest transactions; allow many times the slowest run
  localparam int CYCLE_LIMIT   = 400000;
  // Pause after the last result before touching registers or ending
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [15:0] voltage;
    logic [15:0] hold_time;
    logic [7:0]  position;
  } sample_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  action        = ACT_LOAD;
  logic [7:0]  entry_index   = '0;
  logic [15:0] entry_voltage = '0;
  logic [15:0] entry_hold    = '0;
  logic [7:0]  step_size     = '0;
  logic        paused        = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [15:0] voltage;
  logic [15:0] hold_time;
  logic [7:0]  position;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = CFG_ONE_SHOT;
  logic [15:0] cfg_data      = '0;

  table_waveform_stepper_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .entry_index   (entry_index),
    .entry_voltage (entry_voltage),
    .entry_hold    (entry_hold),
    .step_size     (step_size),
    .paused        (paused),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .voltage       (voltage),
    .hold_time     (hold_time),
    .position      (position),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // Player state mirrored in the testbench: both tables, the play position,
  // the paused-step sum and the three registers at their reset values.
  logic [15:0] volt_mem [256];
  logic [15:0] hold_mem [256];
  int          play_pos  = 0;
  logic [15:0] pause_sum = '0;
  logic        play_once = 1'b0;
  logic [7:0]  size_reg  = 8'd1;
  logic [15:0] end_hold  = '0;

  // Samples the block owes us, oldest first
  sample_t expected_samples [$];

  int errors        = 0;
  int cycles        = 0;
  bit idle_on       = 1'b1;
  int hold_off_left = 0;

  // Watchdog: end the run as failed once the cycle count reaches the limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Apply one accepted transaction to the mirrored player and queue the
  // sample it must produce.
  task automatic advance_player(input logic [1:0] act, input logic [7:0] idx,
                                input logic [15:0] v, input logic [15:0] h,
                                input logic [7:0] st, input logic pz);
    int      n;
    sample_t s;
    // A size of zero plays like a single entry
    n = (size_reg == 8'd0) ? 1 : int'(size_reg);
    case (act)
      ACT_LOAD: begin
        volt_mem[idx] = v;
        hold_mem[idx] = h;
      end
      ACT_STEP: begin
        if (pz) begin
          // Park the step; the sum wraps at 16 bits
          pause_sum = pause_sum + 16'(st);
        end else begin
          // The one-shot end test ignores the parked sum
          if (play_once && play_pos + int'(st) >= n - 1) begin
            play_pos = n - 1;
          end else begin
            play_pos = (play_pos + int'(st) + int'(pause_sum)) % n;
          end
          pause_sum = '0;
        end
      end
      ACT_REWIND: begin
        play_pos = 0;
      end
      default: begin
      end
    endcase
    s.voltage   = volt_mem[play_pos];
    s.hold_time = (play_once && play_pos == n - 1) ? end_hold : hold_mem[play_pos];
    s.position  = 8'(play_pos);
    expected_samples.push_back(s);
  endtask

  // Offer one transaction and hold it until accepted. Called and returns at a
  // rising edge; valid stays high so a back-to-back item needs no gap.
  task automatic send_item(input logic [1:0] act, input logic [7:0] idx,
                           input logic [15:0] v, input logic [15:0] h,
                           input logic [7:0] st, input logic pz);
    if (idle_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    entry_index   <= idx;
    entry_voltage <= v;
    entry_hold    <= h;
    step_size     <= st;
    paused        <= pz;
    do @(posedge clk); while (in_ready !== 1'b1);
    advance_player(act, idx, v, h, st, pz);
  endtask

  // Fields that the action does not use still carry random bits.
  task automatic load_entry(input logic [7:0] idx, input logic [15:0] v,
                            input logic [15:0] h);
    send_item(ACT_LOAD, idx, v, h, 8'($urandom), 1'($urandom));
  endtask

  task automatic step_by(input logic [7:0] st, input logic pz);
    send_item(ACT_STEP, 8'($urandom), 16'($urandom), 16'($urandom), st, pz);
  endtask

  task automatic send_bare(input logic [1:0] act);
    send_item(act, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
              1'($urandom));
  endtask

  // Drop valid, wait for every owed sample, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers on back-to-back edges while the block is idle.
  // Bits above a register's width are random; the unused index is poked too.
  task automatic program_player(input logic os, input logic [7:0] sz,
                                input logic [15:0] fh);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ONE_SHOT;
    cfg_data  <= {15'($urandom), os};
    @(posedge clk);
    cfg_index <= CFG_TABLE_SIZE;
    cfg_data  <= {8'($urandom), sz};
    @(posedge clk);
    cfg_index <= CFG_FINISHED_HOLD;
    cfg_data  <= fh;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    play_once = os;
    size_reg  = sz;
    end_hold  = fh;
  endtask

  // Receiver: check each sample taken, then pick out_ready for the next
  // cycle. A requested hold-off is counted down here, cycle by cycle.
  initial begin
    sample_t want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample with nothing expected: voltage %h hold_time %h position %0d",
                   $time, voltage, hold_time, position);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (voltage !== want.voltage) begin
            $display("%0t: voltage expected %h actual %h", $time, want.voltage, voltage);
            errors++;
          end
          if (hold_time !== want.hold_time) begin
            $display("%0t: hold_time expected %h actual %h", $time, want.hold_time,
                     hold_time);
            errors++;
          end
          if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     position);
            errors++;
          end
        end
      end
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else if (idle_on) begin
        out_ready <= ($urandom_range(99) >= 26);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Fill every table entry before anything reads off position zero. Entry
  // zero goes first since each load reports the entry under the position.
  task automatic test_load_table();
    load_entry(8'd0, 16'h0000, 16'h0000);
    load_entry(8'd255, 16'hFFFF, 16'hFFFF);
    for (int i = 1; i < 255; i++) begin
      load_entry(8'(i), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed_cases();
    // Loop over the full size: zero step, wrap, last position, odd action
    program_player(1'b0, 8'd255, 16'hFFFF);
    step_by(8'd0, 1'b0);
    step_by(8'd255, 1'b0);
    step_by(8'd254, 1'b0);
    send_bare(ACT_UNUSED);
    send_bare(ACT_REWIND);
    // Park two steps, reload an entry while paused, then apply the sum
    step_by(8'd255, 1'b1);
    step_by(8'd1, 1'b1);
    send_item(ACT_LOAD, 8'd4, 16'hFFFF, 16'h0000, 8'hFF, 1'b1);
    step_by(8'd3, 1'b0);

    // One-shot: clamp at the end, stay there, parked sum skips the end test
    program_player(1'b1, 8'd10, 16'h1234);
    send_bare(ACT_REWIND);
    step_by(8'd9, 1'b0);
    step_by(8'd1, 1'b0);
    send_bare(ACT_REWIND);
    step_by(8'd200, 1'b1);
    step_by(8'd2, 1'b0);
    step_by(8'd8, 1'b0);

    // Zero size behaves as one entry, which is also the one-shot end
    program_player(1'b1, 8'd0, 16'h0000);
    step_by(8'd5, 1'b0);
    send_bare(ACT_REWIND);

    // Shrink the size under the position: read there, next step wraps back
    program_player(1'b0, 8'd200, 16'hFFFF);
    step_by(8'd150, 1'b0);
    program_player(1'b0, 8'd20, 16'h0000);
    send_bare(ACT_UNUSED);
    step_by(8'd0, 1'b0);
  endtask

  // Park enough full steps to carry the sum past 16 bits, then apply it.
  task automatic test_pause_wrap();
    program_player(1'b0, 8'd255, 16'($urandom));
    send_bare(ACT_REWIND);
    repeat (258) step_by(8'd255, 1'b1);
    step_by(8'd1, 1'b0);
  endtask

  // Random traffic over a spread of settings. One phase runs with no idling
  // on either side; another holds the receiver off long enough that the
  // block fills and stalls its input.
  task automatic test_random_play();
    logic [7:0]  sz;
    logic [15:0] fh;
    int          pick;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: sz = 8'd1;
        1: sz = 8'd255;
        2: sz = 8'd0;
        3: sz = 8'($urandom_range(2, 8));
        4: sz = 8'($urandom_range(9, 64));
        default: sz = 8'($urandom_range(1, 255));
      endcase
      case (ph % 3)
        0: fh = 16'hFFFF;
        1: fh = 16'h0000;
        default: fh = 16'($urandom);
      endcase
      program_player(ph >= 6, sz, fh);
      idle_on = (ph != 5);
      if (ph == 8) begin
        hold_off_left = 300;
      end
      repeat (100) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          step_by($urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom),
                  $urandom_range(99) < 25);
        end else if (pick < 78) begin
          load_entry(8'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 92) begin
          send_bare(ACT_REWIND);
        end else begin
          send_bare(ACT_UNUSED);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    // Hold reset, then release
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_load_table();
    test_directed_cases();
    test_pause_wrap();
    test_random_play();
    // Drain every owed sample, give the block time to show strays, report
    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== table_waveform_stepper_top.f =====
sv/tws_pkg.sv
sv/tws_ram.sv
sv/tws_ctrl.sv
sv/tws_datapath.sv
sv/table_waveform_stepper_top.sv
verif/tb_table_waveform_stepper_top.sv
